@@ rtl/asl_pkg.sv @@
// Shared types and constants for the averaged sensor logger.
`default_nettype none

package asl_pkg;

  // Command codes carried with each input transaction
  localparam logic [1:0] CMD_SAMPLE      = 2'd0;
  localparam logic [1:0] CMD_TICK        = 2'd1;
  localparam logic [1:0] CMD_ERASE_BEGIN = 2'd2;
  localparam logic [1:0] CMD_ERASE_DONE  = 2'd3;

  // Register indexes on the write port
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_WEIGHT   = 1'b1;

  localparam logic [15:0] INTERVAL_RESET = 16'd60;
  localparam logic [15:0] WEIGHT_RESET   = 16'd10923;
  localparam logic [6:0]  ERASE_MAX      = 7'd127;
  localparam logic [31:0] AVG_MAX        = 32'hFFFF_0000;

  typedef struct packed {
    logic [15:0] first_temperature;
    logic [15:0] first_humidity;
    logic [15:0] second_temperature;
    logic [15:0] second_humidity;
  } pair_t;

  typedef struct packed {
    logic  emit;
    pair_t pair;
  } ctrl_out_t;

endpackage

`default_nettype wire

@@ rtl/averaged_sensor_logger_core.sv @@
// Top level of the averaged sensor logger: input register, update logic, result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------------
//  in      | in        | in_valid / in_stall    | cmd, humidity_ticks, temperature_ticks,
//          |           |                        | elapsed_s
//  out     | out       | out_valid / out_stall  | first_/second_ temperature and humidity
//  cfg     | in        | cfg_write              | cfg_index, cfg_data (no read-back)
//
// Each transaction is registered on entry, then processed out of the input register by one
// Q0.16 x Q16.16 multiply-add per channel plus countdown/slot logic; the result, if any,
// lands in the output register. One transaction per cycle is sustained while out_stall is low.
// The input register holds its transaction while the output register is full and stalled, so
// a stalled result back-pressures in_stall without dropping anything.
// Synchronous reset clears control state and the averages; capture slots are not reset.
`default_nettype none

module averaged_sensor_logger_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [15:0] humidity_ticks,
  input  wire logic [15:0] temperature_ticks,
  input  wire logic [15:0] elapsed_s,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      first_temperature,
  output logic [15:0]      first_humidity,
  output logic [15:0]      second_temperature,
  output logic [15:0]      second_humidity
);

  // config registers
  logic [15:0] interval;
  logic [15:0] weight;

  // input register
  logic        in_full;
  logic [1:0]  cmd_q;
  logic [15:0] hum_q;
  logic [15:0] temp_q;
  logic [15:0] elapsed_q;

  logic        advance;
  logic        fire;
  logic        sample;
  logic [15:0] hum_round;
  logic [15:0] temp_round;

  asl_pkg::ctrl_out_t ctrl_res;
  asl_pkg::pair_t     out_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= asl_pkg::INTERVAL_RESET;
      weight   <= asl_pkg::WEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        asl_pkg::REG_INTERVAL: interval <= cfg_data;
        asl_pkg::REG_WEIGHT:   weight   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // processing stage may move when the result register is free or draining
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;
  assign fire     = in_full && advance;
  assign sample   = fire && (cmd_q == asl_pkg::CMD_SAMPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_q     <= cmd;
      hum_q     <= humidity_ticks;
      temp_q    <= temperature_ticks;
      elapsed_q <= elapsed_s;
    end
  end

  asl_avg_chan u_hum_avg (
    .clk     (clk),
    .rst     (rst),
    .update  (sample),
    .weight  (weight),
    .ticks   (hum_q),
    .rounded (hum_round)
  );

  asl_avg_chan u_temp_avg (
    .clk     (clk),
    .rst     (rst),
    .update  (sample),
    .weight  (weight),
    .ticks   (temp_q),
    .rounded (temp_round)
  );

  asl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .cmd        (cmd_q),
    .elapsed_s  (elapsed_q),
    .interval   (interval),
    .temp_round (temp_round),
    .hum_round  (hum_round),
    .result     (ctrl_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ctrl_res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctrl_res.emit) begin
      out_pair <= ctrl_res.pair;
    end
  end

  assign first_temperature  = out_pair.first_temperature;
  assign first_humidity     = out_pair.first_humidity;
  assign second_temperature = out_pair.second_temperature;
  assign second_humidity    = out_pair.second_humidity;

endmodule

`default_nettype wire

@@ rtl/asl_avg_chan.sv @@
// One exponential average channel: Q16.16 average, weighted step, rounded readout.
`default_nettype none

module asl_avg_chan (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        update,
  input  wire logic [15:0] weight,
  input  wire logic [15:0] ticks,
  output logic      [15:0] rounded
);

  logic [31:0]        avg;
  logic [31:0]        avg_next;
  logic signed [33:0] diff;
  logic signed [50:0] prod;
  logic signed [50:0] prod_rnd;
  logic signed [34:0] step;
  logic signed [35:0] sum;
  logic [32:0]        rnd_sum;

  // step = floor((w * ((x << 16) - avg) + 0.5 LSB) / 2^16), half up
  assign diff     = $signed({2'b00, ticks, 16'h0000}) - $signed({2'b00, avg});
  assign prod     = $signed({{35{1'b0}}, weight}) * $signed({{17{diff[33]}}, diff});
  assign prod_rnd = prod + 51'sd32768;
  assign step     = prod_rnd[50:16];
  assign sum      = $signed({4'b0000, avg}) + $signed({step[34], step});

  always_comb begin
    if (sum[35]) begin
      avg_next = 32'h0000_0000;
    end else if (sum > $signed({4'b0000, asl_pkg::AVG_MAX})) begin
      avg_next = asl_pkg::AVG_MAX;
    end else begin
      avg_next = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= 32'h0000_0000;
    end else if (update) begin
      avg <= avg_next;
    end
  end

  assign rnd_sum = {1'b0, avg} + 33'h0_0000_8000;
  assign rounded = rnd_sum[32] ? 16'hFFFF : rnd_sum[31:16];

endmodule

`default_nettype wire

@@ rtl/asl_ctrl.sv @@
// Countdown, capture slots, pair flushing and erase tracking.
`default_nettype none

module asl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire logic [1:0]           cmd,
  input  wire logic [15:0]          elapsed_s,
  input  wire logic [15:0]          interval,
  input  wire logic [15:0]          temp_round,
  input  wire logic [15:0]          hum_round,
  output asl_pkg::ctrl_out_t        result
);

  logic [15:0] remaining, remaining_next;
  logic [31:0] slot0, slot0_next;
  logic [31:0] slot1, slot1_next;
  logic        slot_index, slot_index_next;
  logic        pair_ready, pair_ready_next;
  logic [6:0]  pending, pending_next;
  logic        writable, writable_next;
  logic        emit;
  logic [16:0] count_diff;
  logic        expire;

  assign count_diff = {1'b0, remaining} - {1'b0, elapsed_s};
  assign expire     = count_diff[16] || (count_diff == 17'd0);

  always_comb begin
    remaining_next  = remaining;
    slot0_next      = slot0;
    slot1_next      = slot1;
    slot_index_next = slot_index;
    pair_ready_next = pair_ready;
    pending_next    = pending;
    writable_next   = writable;
    emit            = 1'b0;
    unique case (cmd)
      asl_pkg::CMD_SAMPLE: begin
      end
      asl_pkg::CMD_TICK: begin
        if (expire) begin
          remaining_next  = interval;
          slot_index_next = ~slot_index;
          if (slot_index) begin
            slot1_next      = {hum_round, temp_round};
            pair_ready_next = 1'b1;
          end else begin
            slot0_next = {hum_round, temp_round};
          end
        end else begin
          remaining_next = count_diff[15:0];
        end
        emit = pair_ready_next && writable;
        if (emit) begin
          pair_ready_next = 1'b0;
        end
      end
      asl_pkg::CMD_ERASE_BEGIN: begin
        if (pending != asl_pkg::ERASE_MAX) begin
          pending_next = pending + 7'd1;
        end
        writable_next = 1'b0;
      end
      asl_pkg::CMD_ERASE_DONE: begin
        if (pending != 7'd0) begin
          pending_next = pending - 7'd1;
        end
        writable_next   = (pending_next == 7'd0);
        emit            = pair_ready;
        pair_ready_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining  <= asl_pkg::INTERVAL_RESET;
      slot_index <= 1'b0;
      pair_ready <= 1'b0;
      pending    <= 7'd0;
      writable   <= 1'b1;
    end else if (fire) begin
      remaining  <= remaining_next;
      slot_index <= slot_index_next;
      pair_ready <= pair_ready_next;
      pending    <= pending_next;
      writable   <= writable_next;
    end
  end

  // slots hold no meaning until captured
  always_ff @(posedge clk) begin
    if (fire) begin
      slot0 <= slot0_next;
      slot1 <= slot1_next;
    end
  end

  assign result.emit                    = fire && emit;
  assign result.pair.first_temperature  = slot0_next[15:0];
  assign result.pair.first_humidity     = slot0_next[31:16];
  assign result.pair.second_temperature = slot1_next[15:0];
  assign result.pair.second_humidity    = slot1_next[31:16];

endmodule

`default_nettype wire

@@ dv/asl_pair_checker.sv @@
// Scoreboard for the averaged sensor logger: tracks the logger state and checks every result pair.
`timescale 1ns / 1ps

module asl_pair_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [15:0] humidity_ticks,
  input  wire logic [15:0] temperature_ticks,
  input  wire logic [15:0] elapsed_s,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [15:0] first_temperature,
  input  wire logic [15:0] first_humidity,
  input  wire logic [15:0] second_temperature,
  input  wire logic [15:0] second_humidity,
  output int               fail_count,
  output int               pairs_waiting,
  output int               pairs_checked
);

  logic [15:0]    interval_q;
  logic [15:0]    weight_q;
  logic [31:0]    hum_avg;
  logic [31:0]    temp_avg;
  int             countdown;
  logic [31:0]    slot_q [2];
  logic           slot_sel;
  logic           pair_held;
  logic [6:0]     erase_cnt;
  logic           writable;
  asl_pkg::pair_t expected_pairs [$];
  int             fails;
  int             checked;

  // avg += round_half_up(w * ((x << 16) - avg) / 2^16), clamped to 0 .. AVG_MAX in Q16.16
  function automatic logic [31:0] ema_next(input logic [31:0] avg, input logic [15:0] ticks,
                                           input logic [15:0] w);
    longint a, x, wl, prod, nxt;
    a    = longint'(avg);
    x    = longint'(ticks);
    wl   = longint'(w);
    prod = wl * ((x <<< 16) - a) + 64'sd32768;
    nxt  = a + (prod >>> 16);
    if (nxt < 0) nxt = 0;
    if (nxt > longint'(asl_pkg::AVG_MAX)) nxt = longint'(asl_pkg::AVG_MAX);
    return nxt[31:0];
  endfunction

  function automatic logic [15:0] rounded(input logic [31:0] avg);
    logic [32:0] r;
    r = ({1'b0, avg} + 33'h8000) >> 16;
    return (r > 33'hFFFF) ? 16'hFFFF : r[15:0];
  endfunction

  task automatic release_pair();
    asl_pkg::pair_t p;
    p.first_temperature  = slot_q[0][15:0];
    p.first_humidity     = slot_q[0][31:16];
    p.second_temperature = slot_q[1][15:0];
    p.second_humidity    = slot_q[1][31:16];
    expected_pairs.push_back(p);
    pair_held = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    asl_pkg::pair_t want;
    if (rst) begin
      interval_q = asl_pkg::INTERVAL_RESET;
      weight_q   = asl_pkg::WEIGHT_RESET;
      hum_avg    = '0;
      temp_avg   = '0;
      countdown  = $signed({16'h0, asl_pkg::INTERVAL_RESET});
      slot_sel   = 1'b0;
      pair_held  = 1'b0;
      erase_cnt  = '0;
      writable   = 1'b1;
      expected_pairs.delete();
      fails      = 0;
      checked    = 0;
    end else begin
      if ($isunknown(out_valid)) begin
        $error("out_valid: expected 0 or 1, got %b", out_valid);
        fails++;
      end
      // results first: anything leaving now came from an earlier transaction
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_pairs.size() == 0) begin
          $error("result pair delivered with none expected");
          fails++;
        end else begin
          want = expected_pairs.pop_front();
          check_field("first_temperature", want.first_temperature, first_temperature);
          check_field("first_humidity", want.first_humidity, first_humidity);
          check_field("second_temperature", want.second_temperature, second_temperature);
          check_field("second_humidity", want.second_humidity, second_humidity);
          checked++;
        end
      end
      if (cfg_write === 1'b1) begin
        if (cfg_index == asl_pkg::REG_INTERVAL) interval_q = cfg_data;
        else weight_q = cfg_data;
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        case (cmd)
          asl_pkg::CMD_SAMPLE: begin
            hum_avg  = ema_next(hum_avg, humidity_ticks, weight_q);
            temp_avg = ema_next(temp_avg, temperature_ticks, weight_q);
          end
          asl_pkg::CMD_TICK: begin
            countdown = countdown - $signed({16'h0, elapsed_s});
            if (countdown <= 0) begin
              countdown         = $signed({16'h0, interval_q});
              slot_q[slot_sel]  = {rounded(hum_avg), rounded(temp_avg)};
              slot_sel          = ~slot_sel;
              if (!slot_sel) pair_held = 1'b1;
            end
            if (pair_held && writable) release_pair();
          end
          asl_pkg::CMD_ERASE_BEGIN: begin
            if (erase_cnt != asl_pkg::ERASE_MAX) erase_cnt++;
            writable = 1'b0;
          end
          asl_pkg::CMD_ERASE_DONE: begin
            if (erase_cnt != '0) erase_cnt--;
            writable = (erase_cnt == '0);
            if (pair_held) release_pair();
          end
          default: ;
        endcase
      end
    end
    fail_count    <= fails;
    pairs_waiting <= expected_pairs.size();
    pairs_checked <= checked;
  end

endmodule

@@ dv/averaged_sensor_logger_core_tb.sv @@
// Testbench top for the averaged sensor logger: stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps

module averaged_sensor_logger_core_tb;

  localparam int RANDOM_PER_PHASE = 270;
  localparam int PHASES           = 6;
  localparam int IDLE_LIMIT       = 2000;  // cycles with no transaction on any port
  localparam int DRAIN_CYCLES     = 6;     // input and result registers plus margin

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = asl_pkg::REG_INTERVAL;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = asl_pkg::CMD_SAMPLE;
  logic [15:0] humidity_ticks = '0;
  logic [15:0] temperature_ticks = '0;
  logic [15:0] elapsed_s = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] first_temperature;
  logic [15:0] first_humidity;
  logic [15:0] second_temperature;
  logic [15:0] second_humidity;

  int fail_count;
  int pairs_waiting;
  int pairs_checked;
  int items_sent = 0;
  int settings_used = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  averaged_sensor_logger_core i_dut (
    .clk, .rst,
    .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .cmd, .humidity_ticks, .temperature_ticks, .elapsed_s,
    .out_valid, .out_stall,
    .first_temperature, .first_humidity, .second_temperature, .second_humidity
  );

  asl_pair_checker i_checker (
    .clk, .rst,
    .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .cmd, .humidity_ticks, .temperature_ticks, .elapsed_s,
    .out_valid, .out_stall,
    .first_temperature, .first_humidity, .second_temperature, .second_humidity,
    .fail_count, .pairs_waiting, .pairs_checked
  );

  // Present one transaction and hold it until taken. The sender runs in bursts; at the
  // end of a burst valid drops for a random gap (or not at all, so that back-to-back
  // bursts also occur). Valid is only lowered when a gap follows, so it never gets two
  // assignments in one step.
  task automatic send(input logic [1:0] op, input logic [15:0] hum, input logic [15:0] temp,
                      input logic [15:0] secs);
    int gap;
    in_valid          <= 1'b1;
    cmd               <= op;
    humidity_ticks    <= hum;
    temperature_ticks <= temp;
    elapsed_s         <= secs;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid, wait for every predicted pair, then let in-flight transactions that give
  // no result drain before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pairs_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers back to back; write enable drops once, after the second.
  task automatic set_config(input logic [15:0] interval, input logic [15:0] weight);
    cfg_write <= 1'b1;
    cfg_index <= asl_pkg::REG_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    cfg_index <= asl_pkg::REG_WEIGHT;
    cfg_data  <= weight;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Receiver back-pressure: stretches of free flow, light and heavy random stalls,
  // and strict alternation.
  initial begin : stall_pattern
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Watchdog: any accepted transaction or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("averaged_sensor_logger_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] ival;
    logic [15:0] wval;
    logic [15:0] span;
    logic [15:0] h;
    logic [15:0] t;
    logic [15:0] e;
    logic [1:0]  op;
    int          roll;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      // a moderate setting, extremes of both registers, the reset values, then a random setting;
      // an interval of zero makes every tick capture
      case (phase)
        0:       begin ival = 16'd10;         wval = 16'h8000;       end
        1:       begin ival = 16'd0;          wval = 16'hFFFF;       end
        2:       begin ival = 16'hFFFF;       wval = 16'd0;          end
        3:       begin ival = 16'd1;          wval = 16'd1;          end
        4:       begin ival = asl_pkg::INTERVAL_RESET; wval = asl_pkg::WEIGHT_RESET; end
        default: begin
          ival = 16'($urandom_range(0, 65535));
          wval = 16'($urandom_range(0, 65535));
        end
      endcase
      set_config(ival, wval);

      if (phase == 0) begin
        // erase done with nothing pending must clamp at zero
        send(asl_pkg::CMD_ERASE_DONE, 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 65535)), 16'hFFFF);
        // averages driven by opposite extremes on the two channels
        send(asl_pkg::CMD_SAMPLE, 16'hFFFF, 16'h0000, 16'($urandom_range(0, 65535)));
        send(asl_pkg::CMD_SAMPLE, 16'h0000, 16'hFFFF, 16'($urandom_range(0, 65535)));
        send(asl_pkg::CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'($urandom_range(0, 65535)));
        // zero-second tick leaves the countdown alone, the largest one captures
        send(asl_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF, 16'd0);
        send(asl_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'hFFFF);
        send(asl_pkg::CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
        // second capture completes the pair, store writable: emitted at once
        send(asl_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'hFFFF);
        // two erases in progress: the next pair is held back
        send(asl_pkg::CMD_ERASE_BEGIN, 16'hFFFF, 16'h0000, 16'h0000);
        send(asl_pkg::CMD_ERASE_BEGIN, 16'h0000, 16'hFFFF, 16'hFFFF);
        send(asl_pkg::CMD_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000);
        send(asl_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'hFFFF);
        send(asl_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'hFFFF);
        send(asl_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'd5);
        // first erase done flushes the held pair though one erase is still open
        send(asl_pkg::CMD_ERASE_DONE, 16'h0000, 16'h0000, 16'h0000);
        send(asl_pkg::CMD_ERASE_DONE, 16'h0000, 16'h0000, 16'h0000);
        send(asl_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'd10);
        send(asl_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'd9);
        send(asl_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'd1);
        send(asl_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'd10);
      end

      if (phase == 1) begin
        // run the erase counter into saturation, send zero-second ticks while blocked, then unwind
        repeat (130)
          send(asl_pkg::CMD_ERASE_BEGIN, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        repeat (6)
          send(asl_pkg::CMD_TICK, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'd0);
        repeat (130)
          send(asl_pkg::CMD_ERASE_DONE, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end

      // Random traffic. Ticks are sized against the interval so captures come often;
      // one in ten uses the full range. Readings lean towards the extremes now and then.
      span = (ival == 16'd0) ? 16'd1 : ival;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 40)      op = asl_pkg::CMD_SAMPLE;
        else if (roll < 80) op = asl_pkg::CMD_TICK;
        else if (roll < 88) op = asl_pkg::CMD_ERASE_BEGIN;
        else                op = asl_pkg::CMD_ERASE_DONE;
        h = ($urandom_range(0, 9) == 0) ? {16{1'($urandom_range(0, 1))}}
                                        : 16'($urandom_range(0, 65535));
        t = ($urandom_range(0, 9) == 0) ? {16{1'($urandom_range(0, 1))}}
                                        : 16'($urandom_range(0, 65535));
        e = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, span));
        send(op, h, t, e);
      end
    end

    settle();
    $display("%0d input transactions over %0d register settings; %0d result pairs compared",
             items_sent, settings_used, pairs_checked);
    if (fail_count == 0 && pairs_waiting == 0) begin
      $display("averaged_sensor_logger_core regression: pass");
    end else begin
      $display("averaged_sensor_logger_core regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/asl_pkg.sv
rtl/asl_avg_chan.sv
rtl/asl_ctrl.sv
rtl/averaged_sensor_logger_core.sv
dv/asl_pair_checker.sv
dv/averaged_sensor_logger_core_tb.sv
